// ===== hw/rtl/mzwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mzwm_pkg: shared types and microcode for the multi-zone window monitor
// Holds the command codes, the control word layout, the program ROM and the
// command dispatch table used by the sequencer and the datapath.
// ----------------------------------------------------------------------------
package mzwm_pkg;

    // item commands (carried in tuser)
    typedef enum logic [2:0] {
        CMD_SAMPLE = 3'd0,
        CMD_LOW    = 3'd1,
        CMD_HIGH   = 3'd2,
        CMD_COUNT  = 3'd3,
        CMD_SWITCH = 3'd4,
        CMD_CLEAR  = 3'd5
    } t_cmd;

    // datapath operation of one microcode step
    typedef enum logic [3:0] {
        OP_NOP    = 4'd0,
        OP_LATCH  = 4'd1,
        OP_ZINIT  = 4'd2,
        OP_READ   = 4'd3,
        OP_EVAL   = 4'd4,
        OP_EMIT   = 4'd5,
        OP_WLOW   = 4'd6,
        OP_WHIGH  = 4'd7,
        OP_WCNT   = 4'd8,
        OP_SWITCH = 4'd9,
        OP_CLEAR  = 4'd10
    } t_op;

    // jump condition: taken goes to target (dispatch: to the command's entry step), otherwise to the next step
    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_BEAT  = 3'd2,
        C_DISPATCH = 3'd3,
        C_ZDONE    = 3'd4,
        C_ZMORE    = 3'd5,
        C_OUT_BUSY = 3'd6
    } t_cond;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    // program addresses
    localparam t_pc A_FETCH  = 4'd0;
    localparam t_pc A_DISP   = 4'd1;
    localparam t_pc A_SINIT  = 4'd2;
    localparam t_pc A_SREAD  = 4'd3;
    localparam t_pc A_SEVAL  = 4'd4;
    localparam t_pc A_OUT    = 4'd5;
    localparam t_pc A_RET    = 4'd6;
    localparam t_pc A_WLOW   = 4'd7;
    localparam t_pc A_WHIGH  = 4'd8;
    localparam t_pc A_WCNT   = 4'd9;
    localparam t_pc A_SWITCH = 4'd10;
    localparam t_pc A_CLEAR  = 4'd11;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // sequencer -> datapath
    typedef struct packed {
        t_op op;
    } t_ctrl;

    // datapath -> sequencer
    typedef struct packed {
        logic       beat;
        logic       out_busy;
        logic       zdone;
        logic       zmore;
        logic [2:0] cmd;
    } t_seq_stat;

    // program ROM
    function automatic t_uword f_rom(input t_pc pc);
        t_uword w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: A_FETCH};
        unique case (pc)
            A_FETCH:  w = '{op: OP_LATCH,  cond: C_NO_BEAT,  target: A_FETCH};
            A_DISP:   w = '{op: OP_NOP,    cond: C_DISPATCH, target: A_FETCH};
            A_SINIT:  w = '{op: OP_ZINIT,  cond: C_ZDONE,    target: A_OUT};
            A_SREAD:  w = '{op: OP_READ,   cond: C_NEXT,     target: A_FETCH};
            A_SEVAL:  w = '{op: OP_EVAL,   cond: C_ZMORE,    target: A_SREAD};
            A_OUT:    w = '{op: OP_EMIT,   cond: C_OUT_BUSY, target: A_OUT};
            A_RET:    w = '{op: OP_NOP,    cond: C_ALWAYS,   target: A_FETCH};
            A_WLOW:   w = '{op: OP_WLOW,   cond: C_ALWAYS,   target: A_OUT};
            A_WHIGH:  w = '{op: OP_WHIGH,  cond: C_ALWAYS,   target: A_OUT};
            A_WCNT:   w = '{op: OP_WCNT,   cond: C_ALWAYS,   target: A_OUT};
            A_SWITCH: w = '{op: OP_SWITCH, cond: C_ALWAYS,   target: A_OUT};
            A_CLEAR:  w = '{op: OP_CLEAR,  cond: C_ALWAYS,   target: A_OUT};
            default:  w = '{op: OP_NOP,    cond: C_ALWAYS,   target: A_FETCH};
        endcase
        return w;
    endfunction

    // command -> entry step; unused codes go straight to the result
    function automatic t_pc f_dispatch(input logic [2:0] cmd);
        t_pc a;
        a = A_OUT;
        unique case (cmd)
            CMD_SAMPLE: a = A_SINIT;
            CMD_LOW:    a = A_WLOW;
            CMD_HIGH:   a = A_WHIGH;
            CMD_COUNT:  a = A_WCNT;
            CMD_SWITCH: a = A_SWITCH;
            CMD_CLEAR:  a = A_CLEAR;
            default:    a = A_OUT;
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/mzwm_ram.sv =====
// ----------------------------------------------------------------------------
// mzwm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mzwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mzwm_seq.sv =====
// ----------------------------------------------------------------------------
// mzwm_seq: microcode sequencer
// Step counter over the program ROM with conditional jumps; emits the
// datapath operation of the current step.
// ----------------------------------------------------------------------------
module mzwm_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mzwm_pkg::t_seq_stat i_stat,
    output mzwm_pkg::t_ctrl     o_ctrl
);

    mzwm_pkg::t_pc    r_pc;
    mzwm_pkg::t_pc    n_pc;
    mzwm_pkg::t_uword w_word;
    logic             w_taken;

    assign w_word = mzwm_pkg::f_rom(r_pc);

    // jump condition decode
    always_comb begin
        w_taken = 1'b0;
        unique case (w_word.cond)
            mzwm_pkg::C_NEXT:     w_taken = 1'b0;
            mzwm_pkg::C_ALWAYS:   w_taken = 1'b1;
            mzwm_pkg::C_NO_BEAT:  w_taken = !i_stat.beat;
            mzwm_pkg::C_DISPATCH: w_taken = 1'b1;
            mzwm_pkg::C_ZDONE:    w_taken = i_stat.zdone;
            mzwm_pkg::C_ZMORE:    w_taken = i_stat.zmore;
            mzwm_pkg::C_OUT_BUSY: w_taken = i_stat.out_busy;
            default:              w_taken = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        if (!w_taken) begin
            n_pc = mzwm_pkg::t_pc'(r_pc + 1'b1);
        end else if (w_word.cond == mzwm_pkg::C_DISPATCH) begin
            n_pc = mzwm_pkg::f_dispatch(i_stat.cmd);
        end else begin
            n_pc = w_word.target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= mzwm_pkg::A_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.op = w_word.op;

endmodule

// ===== hw/rtl/multi_zone_window_monitor.sv =====
// ----------------------------------------------------------------------------
// multi_zone_window_monitor: per-channel multi-window sample monitor
// Microcoded monitor that checks samples against up to ZONES windows per
// channel and drives sticky status bits and an interrupt line.
// ----------------------------------------------------------------------------
// A beat on the slave side carries one command in tuser; every command returns
// exactly one result beat with the status word and the interrupt line level
// after it. A short microprogram runs each command: bound writes, zone count
// writes, switch events and clear run their operation step before the result
// step, unused codes go straight to the result step, and a sample walks the
// N zones of its channel one by one, N being that channel's zone count, each
// needing one read of the bound memories and one evaluation step. The result
// is held in an output register, so the next beat is taken while a result
// still waits; the program stalls only if a second result is ready before
// the first is taken. Bound memories read as zero until written (one valid
// bit per entry).
module multi_zone_window_monitor #(
    parameter int CHANNELS      = 4,
    parameter int ZONES         = 4,
    parameter int LEFT_BIT_BASE = 1,
    parameter int SWITCH_BIT    = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: interrupt_enable
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // channel[1:0], zone[3:2], value[19:4], zeros
    input  logic [2:0]  i_s_tuser,  // command[2:0]
    // results
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata   // irq_status[15:0], interrupt_line[16], zeros
);

    localparam int DEPTH = CHANNELS * ZONES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ZCW   = $clog2(ZONES + 1);

    // status bits that any command can ever set
    function automatic logic [15:0] f_legal_mask();
        logic [15:0] m;
        m = '0;
        m[SWITCH_BIT] = 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
            if (LEFT_BIT_BASE + c <= 15) begin
                m[LEFT_BIT_BASE + c] = 1'b1;
            end
        end
        return m;
    endfunction

    localparam logic [15:0] LEGAL_MASK = f_legal_mask();

    mzwm_pkg::t_ctrl     w_ctrl;
    mzwm_pkg::t_seq_stat w_stat;

    // latched item
    logic [2:0]  r_cmd;
    logic [1:0]  r_ch;
    logic [1:0]  r_zone;
    logic [15:0] r_value;

    // state
    logic [15:0]      r_en;
    logic [15:0]      r_status;
    logic             r_line;
    logic [DEPTH-1:0] r_inside;
    logic [DEPTH-1:0] r_pend;
    logic [DEPTH-1:0] r_lo_valid;
    logic [DEPTH-1:0] r_hi_valid;
    logic [ZCW-1:0]   r_zcnt [CHANNELS];
    logic [ZCW-1:0]   r_j;
    logic             r_lo_ok;
    logic             r_hi_ok;

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_status;
    logic        r_out_line;

    logic [15:0]      n_status;
    logic             n_line;
    logic [DEPTH-1:0] n_inside;
    logic [DEPTH-1:0] n_pend;

    logic           w_ch_ok;
    logic           w_zn_ok;
    logic [CW-1:0]  w_ch_idx;
    logic [ZCW-1:0] w_zcnt_ch;
    logic [AW-1:0]  w_waddr;
    logic [AW-1:0]  w_raddr;
    logic [15:0]    w_ch_mask;
    logic [15:0]    w_lo_rd;
    logic [15:0]    w_hi_rd;
    logic [15:0]    w_lo;
    logic [15:0]    w_hi;
    logic           w_inside;
    logic           w_pend;
    logic           w_raise;
    logic           w_accept;
    logic           w_out_free;
    logic [ZCW:0]   w_j_inc;
    logic [ZCW-1:0] w_cnt_sat;

    mzwm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // item decode
    assign w_ch_ok   = int'(r_ch) < CHANNELS;
    assign w_zn_ok   = int'(r_zone) < ZONES;
    assign w_ch_idx  = CW'(r_ch);
    assign w_zcnt_ch = w_ch_ok ? r_zcnt[w_ch_idx] : '0;
    assign w_waddr   = AW'(int'(w_ch_idx) * ZONES + int'(r_zone));
    assign w_raddr   = AW'(int'(w_ch_idx) * ZONES + int'(r_j));
    assign w_j_inc   = {1'b0, r_j} + 1'b1;
    assign w_cnt_sat = (r_value > 16'(ZONES)) ? ZCW'(ZONES) : r_value[ZCW-1:0];

    // left-window status bit of the current channel
    always_comb begin
        for (int b = 0; b < 16; b++) begin
            w_ch_mask[b] = (b == LEFT_BIT_BASE + int'(r_ch));
        end
    end

    // bound memories
    mzwm_ram #(.WIDTH(16), .DEPTH(DEPTH), .AW(AW)) u_lo_ram (
        .i_clk   (i_clk),
        .i_we    (w_ctrl.op == mzwm_pkg::OP_WLOW && w_ch_ok && w_zn_ok),
        .i_waddr (w_waddr),
        .i_wdata (r_value),
        .i_re    (w_ctrl.op == mzwm_pkg::OP_READ),
        .i_raddr (w_raddr),
        .o_rdata (w_lo_rd)
    );

    mzwm_ram #(.WIDTH(16), .DEPTH(DEPTH), .AW(AW)) u_hi_ram (
        .i_clk   (i_clk),
        .i_we    (w_ctrl.op == mzwm_pkg::OP_WHIGH && w_ch_ok && w_zn_ok),
        .i_waddr (w_waddr),
        .i_wdata (r_value),
        .i_re    (w_ctrl.op == mzwm_pkg::OP_READ),
        .i_raddr (w_raddr),
        .o_rdata (w_hi_rd)
    );

    // window evaluation for the current zone
    assign w_lo     = r_lo_ok ? w_lo_rd : '0;
    assign w_hi     = r_hi_ok ? w_hi_rd : '0;
    assign w_inside = (r_value >= w_lo) && (r_value < w_hi);
    assign w_pend   = r_pend[w_raddr] | (r_inside[w_raddr] & !w_inside);
    assign w_raise  = !r_line && w_pend && ((r_en & w_ch_mask) != '0);

    // handshakes
    assign o_s_tready = (w_ctrl.op == mzwm_pkg::OP_LATCH);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // sequencer status
    assign w_stat.beat     = i_s_tvalid;
    assign w_stat.out_busy = !w_out_free;
    assign w_stat.zdone    = !w_ch_ok || (w_zcnt_ch == '0);
    assign w_stat.zmore    = w_j_inc < {1'b0, w_zcnt_ch};
    assign w_stat.cmd      = r_cmd;

    // status, line and window flags
    always_comb begin
        n_status = r_status;
        n_line   = r_line;
        n_inside = r_inside;
        n_pend   = r_pend;
        case (w_ctrl.op)
            mzwm_pkg::OP_EVAL: begin
                if (w_pend) begin
                    n_status = r_status | w_ch_mask;
                end
                if (w_raise) begin
                    n_line = 1'b1;
                end
                n_pend[w_raddr]   = w_pend & !w_raise;
                n_inside[w_raddr] = w_inside;
            end
            mzwm_pkg::OP_SWITCH: begin
                n_status[SWITCH_BIT] = 1'b1;
                if (r_en[SWITCH_BIT]) begin
                    n_line = 1'b1;
                end
            end
            mzwm_pkg::OP_CLEAR: begin
                n_status = '0;
                n_line   = 1'b0;
                n_pend   = '0;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en        <= '0;
            r_status    <= '0;
            r_line      <= 1'b0;
            r_inside    <= '0;
            r_pend      <= '0;
            r_lo_valid  <= '0;
            r_hi_valid  <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_zcnt[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_en <= i_cfg_wdata;
            end
            r_status <= n_status;
            r_line   <= n_line;
            r_inside <= n_inside;
            r_pend   <= n_pend;
            if (w_ctrl.op == mzwm_pkg::OP_WLOW && w_ch_ok && w_zn_ok) begin
                r_lo_valid[w_waddr] <= 1'b1;
            end
            if (w_ctrl.op == mzwm_pkg::OP_WHIGH && w_ch_ok && w_zn_ok) begin
                r_hi_valid[w_waddr] <= 1'b1;
            end
            if (w_ctrl.op == mzwm_pkg::OP_WCNT && w_ch_ok) begin
                r_zcnt[w_ch_idx] <= w_cnt_sat;
            end
            if (w_ctrl.op == mzwm_pkg::OP_ZINIT) begin
                r_j <= '0;
            end else if (w_ctrl.op == mzwm_pkg::OP_EVAL) begin
                r_j <= w_j_inc[ZCW-1:0];
            end
            if (w_ctrl.op == mzwm_pkg::OP_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_s_tuser;
            r_ch    <= i_s_tdata[1:0];
            r_zone  <= i_s_tdata[3:2];
            r_value <= i_s_tdata[19:4];
        end
        if (w_ctrl.op == mzwm_pkg::OP_READ) begin
            r_lo_ok <= r_lo_valid[w_raddr];
            r_hi_ok <= r_hi_valid[w_raddr];
        end
        if (w_ctrl.op == mzwm_pkg::OP_EMIT && w_out_free) begin
            r_out_status <= r_status;
            r_out_line   <= r_line;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_line, r_out_status};

    // checks
    a_line_has_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line |-> (r_status != '0))
        else $error("interrupt line high with no status bit set");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status & ~LEGAL_MASK) == '0)
        else $error("status bit set that no source maps to");

    a_zone_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == mzwm_pkg::OP_EVAL) |-> (r_j < w_zcnt_ch))
        else $error("zone walk past the channel zone count");

endmodule

// ===== dv/multi_zone_window_monitor_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_zone_window_monitor_checker: result predictor and comparator
// Watches the config port and both stream channels of the window monitor.
// Every accepted input beat is run through a local copy of the window,
// status and interrupt state. The predicted status word and line level are
// queued, and each result beat is compared against the oldest entry.
// ----------------------------------------------------------------------------
module multi_zone_window_monitor_checker #(
    parameter int CHANNELS      = 4,
    parameter int ZONES         = 4,
    parameter int LEFT_BIT_BASE = 1,
    parameter int SWITCH_BIT    = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // channel[1:0], zone[3:2], value[19:4], zeros
    input  logic [2:0]  i_s_tuser,   // command[2:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // irq_status[15:0], interrupt_line[16], zeros
    output int          o_fail_count,
    output int          o_outstanding
);

    typedef struct packed {
        logic [15:0] status;
        logic        line;
    } t_irq_report;

    t_irq_report report_q[$];
    int          mismatches = 0;

    // shadow of the monitor state
    logic [15:0] irq_enable;
    logic [15:0] lo_bound  [CHANNELS][ZONES];
    logic [15:0] hi_bound  [CHANNELS][ZONES];
    logic [2:0]  zones_active [CHANNELS];
    logic        was_in    [CHANNELS][ZONES];
    logic        left_mark [CHANNELS][ZONES];
    logic [15:0] status_word;
    logic        line_level;

    function automatic logic [15:0] status_bit(input int pos);
        if (pos > 15)
            return 16'h0000;
        return 16'h0001 << pos;
    endfunction

    // advance the shadow state by one command beat
    task automatic update_windows(input logic [2:0] cmd, input int ch, input int zn,
                                  input logic [15:0] val);
        logic [15:0] chan_mask;
        int          n;
        logic        hit;
        case (cmd)
            mzwm_pkg::CMD_SAMPLE: begin
                if (ch < CHANNELS) begin
                    chan_mask = status_bit(LEFT_BIT_BASE + ch);
                    n = (zones_active[ch] > ZONES) ? ZONES : int'(zones_active[ch]);
                    // zones in order: a raise here keeps later marks pending
                    for (int j = 0; j < n; j++) begin
                        hit = (val >= lo_bound[ch][j]) && (val < hi_bound[ch][j]);
                        if (was_in[ch][j] && !hit)
                            left_mark[ch][j] = 1'b1;
                        was_in[ch][j] = hit;
                        if (left_mark[ch][j])
                            status_word = status_word | chan_mask;
                        if (!line_level && left_mark[ch][j] &&
                            (irq_enable & chan_mask) != 16'h0000) begin
                            line_level      = 1'b1;
                            left_mark[ch][j] = 1'b0;
                        end
                    end
                end
            end
            mzwm_pkg::CMD_LOW: begin
                if (ch < CHANNELS && zn < ZONES)
                    lo_bound[ch][zn] = val;
            end
            mzwm_pkg::CMD_HIGH: begin
                if (ch < CHANNELS && zn < ZONES)
                    hi_bound[ch][zn] = val;
            end
            mzwm_pkg::CMD_COUNT: begin
                if (ch < CHANNELS)
                    zones_active[ch] = (val <= ZONES) ? val[2:0] : 3'(ZONES);
            end
            mzwm_pkg::CMD_SWITCH: begin
                chan_mask   = status_bit(SWITCH_BIT);
                status_word = status_word | chan_mask;
                if ((irq_enable & chan_mask) != 16'h0000)
                    line_level = 1'b1;
            end
            mzwm_pkg::CMD_CLEAR: begin
                status_word = 16'h0000;
                line_level  = 1'b0;
                for (int c = 0; c < CHANNELS; c++)
                    for (int z = 0; z < ZONES; z++)
                        left_mark[c][z] = 1'b0;
            end
            default: begin
                // spare codes only report the current state
            end
        endcase
    endtask

    // compare result beats first, then predict the beat taken at this edge
    always @(posedge i_clk) begin
        t_irq_report got;
        t_irq_report want;
        if (!i_rst_n) begin
            irq_enable  = 16'h0000;
            status_word = 16'h0000;
            line_level  = 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                zones_active[c] = 3'd0;
                for (int z = 0; z < ZONES; z++) begin
                    lo_bound[c][z]  = 16'h0000;
                    hi_bound[c][z]  = 16'h0000;
                    was_in[c][z]    = 1'b0;
                    left_mark[c][z] = 1'b0;
                end
            end
            report_q.delete();
        end else begin
            if (i_cfg_we)
                irq_enable = i_cfg_wdata;

            if (i_m_tvalid && i_m_tready) begin
                got.status = i_m_tdata[15:0];
                got.line   = i_m_tdata[16];
                if (report_q.size() == 0) begin
                    $error("unexpected result beat: irq_status %h interrupt_line %b",
                           got.status, got.line);
                    mismatches++;
                end else begin
                    want = report_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("irq_status: expected %h, actual %h",
                               want.status, got.status);
                        mismatches++;
                    end
                    if (got.line !== want.line) begin
                        $error("interrupt_line: expected %b, actual %b", want.line, got.line);
                        mismatches++;
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                update_windows(i_s_tuser, int'(i_s_tdata[1:0]), int'(i_s_tdata[3:2]),
                               i_s_tdata[19:4]);
                want.status = status_word;
                want.line   = line_level;
                report_q.push_back(want);
            end
        end
        o_outstanding <= report_q.size();
        o_fail_count  <= mismatches;
    end

endmodule

// ===== dv/multi_zone_window_monitor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_zone_window_monitor_tb: stimulus and verdict for the window monitor
// Runs a directed pass over saturation, window exits, zone ordering, switch
// events, clear and spare codes, then weighted random command streams under
// several interrupt enable settings and handshake idling profiles, with one
// long receiver hold-off. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module multi_zone_window_monitor_tb;

    localparam int CHANNELS      = 4;
    localparam int ZONES         = 4;
    localparam int LEFT_BIT_BASE = 1;
    localparam int SWITCH_BIT    = 0;

    // unused command codes
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam int CLK_HALF_NS    = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int SEGMENTS       = 6;
    localparam int SEGMENT_ITEMS  = 320;
    localparam int BURST_ITEMS    = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 30;
    localparam int RUN_LIMIT_NS   = 8_000_000;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [15:0] cfg_wdata   = 16'h0000;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata     = 24'h000000;
    logic [2:0]  s_tuser     = 3'd0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_toggle   = 1'b0;
    int fail_count;
    int outstanding;

    multi_zone_window_monitor #(
        .CHANNELS      (CHANNELS),
        .ZONES         (ZONES),
        .LEFT_BIT_BASE (LEFT_BIT_BASE),
        .SWITCH_BIT    (SWITCH_BIT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    multi_zone_window_monitor_checker #(
        .CHANNELS      (CHANNELS),
        .ZONES         (ZONES),
        .LEFT_BIT_BASE (LEFT_BIT_BASE),
        .SWITCH_BIT    (SWITCH_BIT)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        #RUN_LIMIT_NS;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random back-pressure, plus a long hold-off on request
    int hold_left = 0;
    bit hold_seen = 1'b0;
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // offer one beat, with random idle cycles first; returns at the accepting edge
    task automatic send_item(input logic [2:0] cmd, input logic [1:0] ch,
                             input logic [1:0] zn, input logic [15:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'h0, val, zn, ch};
        @(negedge i_clk);
        while (!s_tready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_irq_enable(input logic [15:0] val);
        wait_results_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // sample and bound values cluster in a narrow band so windows get crossed
    function automatic logic [15:0] pick_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 16'($urandom_range(0, 15));
        else if (r < 88)
            return 16'($urandom);
        else if (r < 94)
            return 16'h0000;
        return 16'hFFFF;
    endfunction

    function automatic logic [15:0] pick_zone_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 16'($urandom_range(0, ZONES));
        else if (r < 90)
            return 16'($urandom_range(ZONES + 1, 7));
        return 16'($urandom);
    endfunction

    task automatic send_random_item();
        int          pick;
        logic [2:0]  cmd;
        logic [1:0]  ch;
        logic [1:0]  zn;
        logic [15:0] val;
        ch   = 2'($urandom_range(0, 3));
        zn   = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            cmd = mzwm_pkg::CMD_SAMPLE;
            val = pick_level();
        end else if (pick < 70) begin
            cmd = mzwm_pkg::CMD_LOW;
            val = pick_level();
        end else if (pick < 80) begin
            cmd = mzwm_pkg::CMD_HIGH;
            val = pick_level();
        end else if (pick < 86) begin
            cmd = mzwm_pkg::CMD_COUNT;
            val = pick_zone_count();
        end else if (pick < 91) begin
            cmd = mzwm_pkg::CMD_SWITCH;
            val = 16'($urandom);
        end else if (pick < 96) begin
            cmd = mzwm_pkg::CMD_CLEAR;
            val = 16'($urandom);
        end else begin
            cmd = pick[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
            val = 16'($urandom);
        end
        send_item(cmd, ch, zn, val);
    endtask

    function automatic logic [15:0] segment_enable(input int seg);
        case (seg)
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            3:       return 16'h0001;
            5:       return 16'h001E;
            default: return 16'($urandom);
        endcase
    endfunction

    // stimulus and verdict
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: enable still at its reset value of zero
        send_item(mzwm_pkg::CMD_SAMPLE, 2'd0, 2'd0, 16'h0000);   // no zones configured
        send_item(CMD_SPARE_LO,         2'd3, 2'd3, 16'hFFFF);
        send_item(CMD_SPARE_HI,         2'd0, 2'd0, 16'h0000);
        send_item(mzwm_pkg::CMD_SWITCH, 2'd2, 2'd1, 16'h1234);   // status only
        send_item(mzwm_pkg::CMD_CLEAR,  2'd3, 2'd3, 16'hFFFF);
        send_item(mzwm_pkg::CMD_COUNT,  2'd3, 2'd0, 16'hFFFF);   // saturates
        send_item(mzwm_pkg::CMD_COUNT,  2'd1, 2'd0, 16'd5);      // saturates
        send_item(mzwm_pkg::CMD_COUNT,  2'd0, 2'd0, 16'd4);
        send_item(mzwm_pkg::CMD_LOW,    2'd0, 2'd0, 16'h0000);
        send_item(mzwm_pkg::CMD_HIGH,   2'd0, 2'd0, 16'hFFFF);
        send_item(mzwm_pkg::CMD_LOW,    2'd0, 2'd1, 16'd100);
        send_item(mzwm_pkg::CMD_HIGH,   2'd0, 2'd1, 16'd200);
        send_item(mzwm_pkg::CMD_LOW,    2'd0, 2'd2, 16'hFFFF);   // empty window
        send_item(mzwm_pkg::CMD_HIGH,   2'd0, 2'd2, 16'hFFFF);
        send_item(mzwm_pkg::CMD_LOW,    2'd0, 2'd3, 16'h0000);
        send_item(mzwm_pkg::CMD_HIGH,   2'd0, 2'd3, 16'h0000);
        send_item(mzwm_pkg::CMD_SAMPLE, 2'd0, 2'd0, 16'd150);    // inside zones 0 and 1
        send_item(mzwm_pkg::CMD_SAMPLE, 2'd0, 2'd0, 16'hFFFF);   // leaves both, marks stay
        write_irq_enable(16'hFFFF);
        send_item(mzwm_pkg::CMD_SAMPLE, 2'd0, 2'd0, 16'd150);    // zone 0 raises, 1 waits
        send_item(mzwm_pkg::CMD_SAMPLE, 2'd0, 2'd0, 16'd50);     // leaves zone 1, line high
        send_item(mzwm_pkg::CMD_SWITCH, 2'd0, 2'd0, 16'h0000);
        send_item(mzwm_pkg::CMD_CLEAR,  2'd0, 2'd0, 16'h0000);
        send_item(mzwm_pkg::CMD_SAMPLE, 2'd0, 2'd0, 16'd300);
        send_item(mzwm_pkg::CMD_COUNT,  2'd0, 2'd0, 16'd0);
        send_item(mzwm_pkg::CMD_SAMPLE, 2'd0, 2'd0, 16'h0000);   // windows frozen

        // random: two segments per idling profile
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 2)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 46;
                end
                1: begin
                    send_idle_pct = 46;
                    recv_idle_pct = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_irq_enable(segment_enable(seg));
            repeat (SEGMENT_ITEMS) send_random_item();
        end

        // back-pressure burst: result side holds off, input side fills up
        write_irq_enable(16'hFFFF);
        hold_toggle = ~hold_toggle;
        repeat (BURST_ITEMS) send_random_item();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
